[design/sra_pkg.sv]
package sra_pkg;

    // default sequence space
    localparam int unsigned SEQ_COUNT_DEF = 32;

    // field widths of the event, command and configuration beats
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned FTYPE_W   = 2;
    localparam int unsigned FSEQ_W    = 5;
    localparam int unsigned FLEN_W    = 10;
    localparam int unsigned TSLOT_W   = 4;
    localparam int unsigned ACT_W     = 3;
    localparam int unsigned SLOT_W    = 4;
    localparam int unsigned TICKS_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_PKT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PHYS  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DTO   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ATO   = 3'd4;

    // frame types
    localparam logic [FTYPE_W-1:0] TYPE_DATA = 2'd0;
    localparam logic [FTYPE_W-1:0] TYPE_ACK  = 2'd1;
    localparam logic [FTYPE_W-1:0] TYPE_NAK  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT  = 1'b1;

    localparam logic [TICKS_W-1:0] DATA_TO_RESET = 16'd4000;
    localparam logic [TICKS_W-1:0] ACK_TO_RESET  = 16'd2500;

    // header plus crc bytes stripped on delivery
    localparam logic [FLEN_W-1:0] HDR_CRC_BYTES = 10'd7;

    typedef enum logic [ACT_W-1:0] {
        ACT_SEND,
        ACT_DELIVER,
        ACT_START_DATA,
        ACT_STOP_DATA,
        ACT_START_ACK,
        ACT_STOP_ACK,
        ACT_STATUS
    } act_t;

    // datapath operations of one control word
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_NEW,
        OP_SET_PHYS,
        OP_LOAD_ACK,
        OP_LOAD_NAK,
        OP_LOAD_RESEND,
        OP_LOAD_RS,
        OP_MARK,
        OP_ADVANCE_RX,
        OP_RELEASE_TX,
        OP_SENT
    } op_t;

    // jump conditions
    typedef enum logic [4:0] {
        C_ALWAYS,
        C_KIND_PKT,
        C_KIND_PHYS,
        C_KIND_FRAME,
        C_KIND_DTO,
        C_KIND_ATO,
        C_WIN_FULL,
        C_BAD,
        C_NOT_DATA,
        C_NO_NAK_SEND,
        C_NOT_ACCEPT,
        C_NOT_ARRIVED,
        C_NOT_NAK,
        C_RS_OUT,
        C_ACK_OUT,
        C_NAK_BLOCKED,
        C_STYPE_NOT_DATA
    } cond_t;

    localparam int unsigned PC_W = 6;
    typedef logic [PC_W-1:0] pc_t;

    // program labels
    localparam pc_t A_DISP0      = 6'd0;
    localparam pc_t A_DISP1      = 6'd1;
    localparam pc_t A_DISP2      = 6'd2;
    localparam pc_t A_DISP3      = 6'd3;
    localparam pc_t A_DISP4      = 6'd4;
    localparam pc_t A_DISP5      = 6'd5;
    localparam pc_t A_PKT        = 6'd6;
    localparam pc_t A_PKT_SEND   = 6'd7;
    localparam pc_t A_PKT_END    = 6'd8;
    localparam pc_t A_PHYS       = 6'd9;
    localparam pc_t A_ATO        = 6'd10;
    localparam pc_t A_ATO_END    = 6'd11;
    localparam pc_t A_DTO        = 6'd12;
    localparam pc_t A_DTO_END    = 6'd13;
    localparam pc_t A_FRAME      = 6'd14;
    localparam pc_t A_F_TYPE     = 6'd15;
    localparam pc_t A_F_NAKQ     = 6'd16;
    localparam pc_t A_F_NAK      = 6'd17;
    localparam pc_t A_F_NAK_END  = 6'd18;
    localparam pc_t A_F_ACK      = 6'd19;
    localparam pc_t A_F_WIN      = 6'd20;
    localparam pc_t A_F_MARK     = 6'd21;
    localparam pc_t A_F_LOOP     = 6'd22;
    localparam pc_t A_F_DELIVER  = 6'd23;
    localparam pc_t A_F_REARM    = 6'd24;
    localparam pc_t A_F_NAKCHK   = 6'd25;
    localparam pc_t A_F_RS       = 6'd26;
    localparam pc_t A_F_RS_CHK   = 6'd27;
    localparam pc_t A_F_RESEND   = 6'd28;
    localparam pc_t A_ACKLOOP    = 6'd29;
    localparam pc_t A_ACK_STOP   = 6'd30;
    localparam pc_t A_BAD        = 6'd31;
    localparam pc_t A_BAD_NAK    = 6'd32;
    localparam pc_t A_BAD_END    = 6'd33;
    localparam pc_t A_STATUS     = 6'd34;
    localparam pc_t A_SEND       = 6'd35;
    localparam pc_t A_SEND_TMR   = 6'd36;
    localparam pc_t A_SEND_END   = 6'd37;
    localparam pc_t PROG_LEN     = 6'd38;

    typedef struct packed {
        logic  emit;
        act_t  act;
        op_t   op;
        cond_t cond;
        pc_t   target;
        logic  call;
        logic  ret;
        logic  fin;
    } uword_t;

    // sequencer to datapath control
    typedef struct packed {
        logic   busy;
        logic   step;
        uword_t word;
    } seq_ctl_t;

    function automatic uword_t mk(input logic e, input act_t a, input op_t o,
                                  input cond_t c, input pc_t t, input logic cl,
                                  input logic rt, input logic fn);
        uword_t w;
        w.emit   = e;
        w.act    = a;
        w.op     = o;
        w.cond   = c;
        w.target = t;
        w.call   = cl;
        w.ret    = rt;
        w.fin    = fn;
        return w;
    endfunction

    // control store
    function automatic uword_t rom_word(input pc_t a);
        uword_t w;
        case (a)
            // dispatch on event kind
            A_DISP0:     w = mk(1'b0, ACT_SEND, OP_NONE, C_KIND_PKT, A_PKT, 1'b0, 1'b0, 1'b0);
            A_DISP1:     w = mk(1'b0, ACT_SEND, OP_NONE, C_KIND_PHYS, A_PHYS, 1'b0, 1'b0, 1'b0);
            A_DISP2:     w = mk(1'b0, ACT_SEND, OP_NONE, C_KIND_FRAME, A_FRAME,
                                1'b0, 1'b0, 1'b0);
            A_DISP3:     w = mk(1'b0, ACT_SEND, OP_NONE, C_KIND_DTO, A_DTO, 1'b0, 1'b0, 1'b0);
            A_DISP4:     w = mk(1'b0, ACT_SEND, OP_NONE, C_KIND_ATO, A_ATO, 1'b0, 1'b0, 1'b0);
            A_DISP5:     w = mk(1'b0, ACT_SEND, OP_NONE, C_ALWAYS, A_STATUS, 1'b0, 1'b0, 1'b0);
            // new packet from the network layer
            A_PKT:       w = mk(1'b0, ACT_SEND, OP_NONE, C_WIN_FULL, A_STATUS,
                                1'b0, 1'b0, 1'b0);
            A_PKT_SEND:  w = mk(1'b0, ACT_SEND, OP_LOAD_NEW, C_ALWAYS, A_SEND,
                                1'b1, 1'b0, 1'b0);
            A_PKT_END:   w = mk(1'b0, ACT_SEND, OP_NONE, C_ALWAYS, A_STATUS, 1'b0, 1'b0, 1'b0);
            A_PHYS:      w = mk(1'b0, ACT_SEND, OP_SET_PHYS, C_ALWAYS, A_STATUS,
                                1'b0, 1'b0, 1'b0);
            // ack timer expiry
            A_ATO:       w = mk(1'b0, ACT_SEND, OP_LOAD_ACK, C_ALWAYS, A_SEND,
                                1'b1, 1'b0, 1'b0);
            A_ATO_END:   w = mk(1'b0, ACT_SEND, OP_NONE, C_ALWAYS, A_STATUS, 1'b0, 1'b0, 1'b0);
            // data timer expiry
            A_DTO:       w = mk(1'b0, ACT_SEND, OP_LOAD_RESEND, C_ALWAYS, A_SEND,
                                1'b1, 1'b0, 1'b0);
            A_DTO_END:   w = mk(1'b0, ACT_SEND, OP_NONE, C_ALWAYS, A_STATUS, 1'b0, 1'b0, 1'b0);
            // received frame
            A_FRAME:     w = mk(1'b0, ACT_SEND, OP_NONE, C_BAD, A_BAD, 1'b0, 1'b0, 1'b0);
            A_F_TYPE:    w = mk(1'b0, ACT_SEND, OP_NONE, C_NOT_DATA, A_F_NAKCHK,
                                1'b0, 1'b0, 1'b0);
            A_F_NAKQ:    w = mk(1'b0, ACT_SEND, OP_NONE, C_NO_NAK_SEND, A_F_ACK,
                                1'b0, 1'b0, 1'b0);
            A_F_NAK:     w = mk(1'b0, ACT_SEND, OP_LOAD_NAK, C_ALWAYS, A_SEND,
                                1'b1, 1'b0, 1'b0);
            A_F_NAK_END: w = mk(1'b0, ACT_SEND, OP_NONE, C_ALWAYS, A_F_WIN, 1'b0, 1'b0, 1'b0);
            A_F_ACK:     w = mk(1'b1, ACT_START_ACK, OP_NONE, C_ALWAYS, A_F_WIN,
                                1'b0, 1'b0, 1'b0);
            A_F_WIN:     w = mk(1'b0, ACT_SEND, OP_NONE, C_NOT_ACCEPT, A_F_NAKCHK,
                                1'b0, 1'b0, 1'b0);
            A_F_MARK:    w = mk(1'b0, ACT_SEND, OP_MARK, C_ALWAYS, A_F_LOOP, 1'b0, 1'b0, 1'b0);
            A_F_LOOP:    w = mk(1'b0, ACT_SEND, OP_NONE, C_NOT_ARRIVED, A_F_NAKCHK,
                                1'b0, 1'b0, 1'b0);
            A_F_DELIVER: w = mk(1'b1, ACT_DELIVER, OP_ADVANCE_RX, C_ALWAYS, A_F_REARM,
                                1'b0, 1'b0, 1'b0);
            A_F_REARM:   w = mk(1'b1, ACT_START_ACK, OP_NONE, C_ALWAYS, A_F_LOOP,
                                1'b0, 1'b0, 1'b0);
            A_F_NAKCHK:  w = mk(1'b0, ACT_SEND, OP_NONE, C_NOT_NAK, A_ACKLOOP,
                                1'b0, 1'b0, 1'b0);
            A_F_RS:      w = mk(1'b0, ACT_SEND, OP_LOAD_RS, C_ALWAYS, A_F_RS_CHK,
                                1'b0, 1'b0, 1'b0);
            A_F_RS_CHK:  w = mk(1'b0, ACT_SEND, OP_NONE, C_RS_OUT, A_ACKLOOP,
                                1'b0, 1'b0, 1'b0);
            A_F_RESEND:  w = mk(1'b0, ACT_SEND, OP_NONE, C_ALWAYS, A_SEND, 1'b1, 1'b0, 1'b0);
            A_ACKLOOP:   w = mk(1'b0, ACT_SEND, OP_NONE, C_ACK_OUT, A_STATUS,
                                1'b0, 1'b0, 1'b0);
            A_ACK_STOP:  w = mk(1'b1, ACT_STOP_DATA, OP_RELEASE_TX, C_ALWAYS, A_ACKLOOP,
                                1'b0, 1'b0, 1'b0);
            // damaged frame
            A_BAD:       w = mk(1'b0, ACT_SEND, OP_NONE, C_NAK_BLOCKED, A_STATUS,
                                1'b0, 1'b0, 1'b0);
            A_BAD_NAK:   w = mk(1'b0, ACT_SEND, OP_LOAD_NAK, C_ALWAYS, A_SEND,
                                1'b1, 1'b0, 1'b0);
            A_BAD_END:   w = mk(1'b0, ACT_SEND, OP_NONE, C_ALWAYS, A_STATUS, 1'b0, 1'b0, 1'b0);
            // closing status beat
            A_STATUS:    w = mk(1'b1, ACT_STATUS, OP_NONE, C_ALWAYS, A_DISP0, 1'b0, 1'b0, 1'b1);
            // send subroutine
            A_SEND:      w = mk(1'b1, ACT_SEND, OP_SENT, C_STYPE_NOT_DATA, A_SEND_END,
                                1'b0, 1'b0, 1'b0);
            A_SEND_TMR:  w = mk(1'b1, ACT_START_DATA, OP_NONE, C_ALWAYS, A_SEND_END,
                                1'b0, 1'b0, 1'b0);
            A_SEND_END:  w = mk(1'b1, ACT_STOP_ACK, OP_NONE, C_ALWAYS, A_DISP0,
                                1'b0, 1'b1, 1'b0);
            default:     w = mk(1'b0, ACT_SEND, OP_NONE, C_ALWAYS, A_STATUS, 1'b0, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

endpackage

[design/sra_evt_if.sv]
interface sra_evt_if;
    import sra_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic                 frame_good;
    logic [FTYPE_W-1:0]   frame_type;
    logic [FSEQ_W-1:0]    frame_seq;
    logic [FSEQ_W-1:0]    peer_ack;
    logic [FLEN_W-1:0]    frame_length;
    logic [TSLOT_W-1:0]   timer_slot;

    modport source (
        output valid, kind, frame_good, frame_type, frame_seq, peer_ack,
               frame_length, timer_slot,
        input  ready
    );

    modport sink (
        input  valid, kind, frame_good, frame_type, frame_seq, peer_ack,
               frame_length, timer_slot,
        output ready
    );

endinterface

[design/sra_cmd_if.sv]
interface sra_cmd_if;
    import sra_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACT_W-1:0]     action;
    logic [FTYPE_W-1:0]   send_type;
    logic [FSEQ_W-1:0]    send_seq;
    logic [FSEQ_W-1:0]    send_ack;
    logic [SLOT_W-1:0]    buffer_slot;
    logic [FLEN_W-1:0]    packet_length;
    logic [TICKS_W-1:0]   timer_ticks;
    logic                 network_enable;
    logic                 last;

    modport source (
        output valid, action, send_type, send_seq, send_ack, buffer_slot,
               packet_length, timer_ticks, network_enable, last,
        input  ready
    );

    modport sink (
        input  valid, action, send_type, send_seq, send_ack, buffer_slot,
               packet_length, timer_ticks, network_enable, last,
        output ready
    );

endinterface

[design/sra_cfg_if.sv]
interface sra_cfg_if;
    import sra_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [TICKS_W-1:0]   data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );

endinterface

[design/selective_repeat_arq_control_core.sv]
// Selective repeat ARQ link controller.
// evt carries one link event per beat (packet ready, physical ready, frame
// received, data timeout, ack timeout). cmd returns the commands that event
// causes, in order: frame sends, deliveries, timer starts and stops, closing
// with one status beat (last = 1) that carries the network enable.
// cfg writes the data and ack timer durations and is always ready; it is to be
// written only while no event is in flight, which the block does not enforce.
// A short program in a control store walks each event, one control word per
// cycle; a word that emits a command waits while the output register is full.
// The shortest event is a packet ready with a full window, the longest a frame
// that releases a full window of deliveries and acks; a command beat held by a
// stalled receiver holds the program with it.
// The next event can be taken in the same cycle that the status beat first
// sits in the output register.
// Reset clears the window pointers, arrived flags and timer durations to
// their initial values; no clearing pass is needed.
module selective_repeat_arq_control_core #(
    parameter int unsigned SEQ_COUNT = sra_pkg::SEQ_COUNT_DEF
) (
    input  logic clk,
    input  logic rst_n,
    sra_evt_if.sink   evt,
    sra_cmd_if.source cmd,
    sra_cfg_if.sink   cfg
);
    import sra_pkg::*;

    localparam int unsigned W    = SEQ_COUNT / 2;
    localparam int unsigned SW   = $clog2(SEQ_COUNT);
    localparam int unsigned SW1  = SW + 1;
    localparam int unsigned WB   = $clog2(W);
    localparam int unsigned OC_W = $clog2(W + 1);

    // modulo helpers on sequence numbers
    function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] s);
        return (s == SW'(SEQ_COUNT - 1)) ? '0 : s + SW'(1);
    endfunction

    function automatic logic [SW-1:0] seq_dec(input logic [SW-1:0] s);
        return (s == '0) ? SW'(SEQ_COUNT - 1) : s - SW'(1);
    endfunction

    function automatic logic [SW-1:0] seq_add_w(input logic [SW-1:0] s);
        logic [SW:0] t;
        t = {1'b0, s} + SW1'(W);
        if (t >= SW1'(SEQ_COUNT))
            t = t - SW1'(SEQ_COUNT);
        return t[SW-1:0];
    endfunction

    function automatic logic [WB-1:0] slot_of(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = s;
        if (t >= SW'(W))
            t = t - SW'(W);
        if (t >= SW'(W))
            t = t - SW'(W);
        return t[WB-1:0];
    endfunction

    function automatic logic [SW-1:0] seq_in(input logic [FSEQ_W-1:0] v);
        logic [8:0] t;
        t = 9'(v);
        for (int i = 0; i < 8; i++)
            if (t >= 9'(SEQ_COUNT))
                t = t - 9'(SEQ_COUNT);
        return t[SW-1:0];
    endfunction

    function automatic logic [WB-1:0] tslot_in(input logic [TSLOT_W-1:0] v);
        logic [8:0] t;
        t = 9'(v);
        for (int i = 0; i < 8; i++)
            if (t >= 9'(W))
                t = t - 9'(W);
        return t[WB-1:0];
    endfunction

    function automatic logic in_win(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                    input logic [SW-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    function automatic logic [FSEQ_W-1:0] to_seq_field(input logic [SW-1:0] s);
        logic [7:0] x;
        x = 8'(s);
        return x[FSEQ_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] to_slot_field(input logic [WB-1:0] s);
        logic [7:0] x;
        x = 8'(s);
        return x[SLOT_W-1:0];
    endfunction

    seq_ctl_t ctl;
    logic     cond_hit;
    logic     out_free;
    logic     evt_fire;
    logic     cfg_fire;

    // link state
    logic [SW-1:0]      nts_reg, nts_next;
    logic [SW-1:0]      old_reg, old_next;
    logic [SW-1:0]      rle_reg, rle_next;
    logic [SW-1:0]      rue_reg, rue_next;
    logic [OC_W-1:0]    outc_reg, outc_next;
    logic [W-1:0]       arr_reg, arr_next;
    logic               nak_ok_reg, nak_ok_next;
    logic               phys_reg, phys_next;
    logic [TICKS_W-1:0] data_to_reg, data_to_next;
    logic [TICKS_W-1:0] ack_to_reg, ack_to_next;
    logic               cmd_valid_reg, cmd_valid_next;

    // frame to send
    logic [SW-1:0]      sseq_reg, sseq_next;
    logic [FTYPE_W-1:0] stype_reg, stype_next;

    // latched event
    logic [KIND_W-1:0]  kind_reg;
    logic               good_reg;
    logic [FTYPE_W-1:0] ftype_reg;
    logic [SW-1:0]      fseq_reg;
    logic [SW-1:0]      fack_reg;
    logic [FLEN_W-1:0]  flen_reg;
    logic [WB-1:0]      tslot_reg;

    // output register payload
    logic [ACT_W-1:0]   o_act_reg, o_act_next;
    logic [FTYPE_W-1:0] o_type_reg, o_type_next;
    logic [FSEQ_W-1:0]  o_seq_reg, o_seq_next;
    logic [FSEQ_W-1:0]  o_ack_reg, o_ack_next;
    logic [SLOT_W-1:0]  o_slot_reg, o_slot_next;
    logic [FLEN_W-1:0]  o_len_reg, o_len_next;
    logic [TICKS_W-1:0] o_ticks_reg, o_ticks_next;
    logic               o_ne_reg, o_ne_next;
    logic               o_last_reg, o_last_next;

    logic [WB-1:0]      fslot;
    logic [WB-1:0]      rslot;
    logic [WB-1:0]      sslot;
    logic [WB-1:0]      oslot;
    logic               arr_rd;
    logic [FLEN_W-1:0]  plen;
    logic [SW-1:0]      tseq;

    assign out_free = !cmd_valid_reg || cmd.ready;
    assign evt.ready = !ctl.busy;
    assign cfg.ready = 1'b1;
    assign evt_fire  = evt.valid && evt.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;

    sra_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (evt_fire),
        .out_free (out_free),
        .cond_hit (cond_hit),
        .ctl      (ctl)
    );

    assign fslot = slot_of(fseq_reg);
    assign rslot = slot_of(rle_reg);
    assign sslot = slot_of(sseq_reg);
    assign oslot = slot_of(old_reg);
    assign tseq  = SW'(tslot_reg);
    assign plen  = (flen_reg >= HDR_CRC_BYTES) ? flen_reg - HDR_CRC_BYTES : '0;

    // one read port on the arrived flags
    assign arr_rd = arr_reg[(ctl.word.cond == C_NOT_ACCEPT) ? fslot : rslot];

    // jump condition select
    always_comb
    begin
        case (ctl.word.cond)
            C_ALWAYS:         cond_hit = 1'b1;
            C_KIND_PKT:       cond_hit = (kind_reg == KIND_PKT);
            C_KIND_PHYS:      cond_hit = (kind_reg == KIND_PHYS);
            C_KIND_FRAME:     cond_hit = (kind_reg == KIND_FRAME);
            C_KIND_DTO:       cond_hit = (kind_reg == KIND_DTO);
            C_KIND_ATO:       cond_hit = (kind_reg == KIND_ATO);
            C_WIN_FULL:       cond_hit = (outc_reg >= OC_W'(W));
            C_BAD:            cond_hit = !good_reg;
            C_NOT_DATA:       cond_hit = (ftype_reg != TYPE_DATA);
            C_NO_NAK_SEND:    cond_hit = (fseq_reg == rle_reg) || !nak_ok_reg;
            C_NOT_ACCEPT:     cond_hit = !(in_win(rle_reg, fseq_reg, rue_reg) && !arr_rd);
            C_NOT_ARRIVED:    cond_hit = !arr_rd;
            C_NOT_NAK:        cond_hit = (ftype_reg != TYPE_NAK);
            C_RS_OUT:         cond_hit = !in_win(old_reg, sseq_reg, nts_reg);
            C_ACK_OUT:        cond_hit = !in_win(old_reg, fack_reg, nts_reg);
            C_NAK_BLOCKED:    cond_hit = !nak_ok_reg;
            C_STYPE_NOT_DATA: cond_hit = (stype_reg != TYPE_DATA);
            default:          cond_hit = 1'b0;
        endcase
    end

    // datapath operations and configuration writes
    always_comb
    begin
        nts_next     = nts_reg;
        old_next     = old_reg;
        rle_next     = rle_reg;
        rue_next     = rue_reg;
        outc_next    = outc_reg;
        arr_next     = arr_reg;
        nak_ok_next  = nak_ok_reg;
        phys_next    = phys_reg;
        sseq_next    = sseq_reg;
        stype_next   = stype_reg;
        data_to_next = data_to_reg;
        ack_to_next  = ack_to_reg;

        if (cfg_fire)
        begin
            case (cfg.index)
                CFG_DATA_TIMEOUT: data_to_next = cfg.data;
                CFG_ACK_TIMEOUT:  ack_to_next  = cfg.data;
                default:          ;
            endcase
        end

        if (ctl.step)
        begin
            case (ctl.word.op)
                OP_LOAD_NEW:
                begin
                    outc_next  = outc_reg + OC_W'(1);
                    sseq_next  = nts_reg;
                    stype_next = TYPE_DATA;
                    nts_next   = seq_inc(nts_reg);
                end
                OP_SET_PHYS:
                begin
                    phys_next = 1'b1;
                end
                OP_LOAD_ACK:
                begin
                    sseq_next  = '0;
                    stype_next = TYPE_ACK;
                end
                OP_LOAD_NAK:
                begin
                    sseq_next  = '0;
                    stype_next = TYPE_NAK;
                end
                OP_LOAD_RESEND:
                begin
                    // slot outside the send window means the upper half sequence
                    sseq_next  = in_win(old_reg, tseq, nts_reg) ? tseq : tseq + SW'(W);
                    stype_next = TYPE_DATA;
                end
                OP_LOAD_RS:
                begin
                    sseq_next  = seq_inc(fack_reg);
                    stype_next = TYPE_DATA;
                end
                OP_MARK:
                begin
                    arr_next[fslot] = 1'b1;
                end
                OP_ADVANCE_RX:
                begin
                    nak_ok_next     = 1'b1;
                    arr_next[rslot] = 1'b0;
                    rle_next        = seq_inc(rle_reg);
                    rue_next        = seq_inc(rue_reg);
                end
                OP_RELEASE_TX:
                begin
                    if (outc_reg != '0)
                        outc_next = outc_reg - OC_W'(1);
                    old_next = seq_inc(old_reg);
                end
                OP_SENT:
                begin
                    phys_next = 1'b0;
                    if (stype_reg == TYPE_NAK)
                        nak_ok_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // command beat formed from the current word
    always_comb
    begin
        o_act_next   = o_act_reg;
        o_type_next  = o_type_reg;
        o_seq_next   = o_seq_reg;
        o_ack_next   = o_ack_reg;
        o_slot_next  = o_slot_reg;
        o_len_next   = o_len_reg;
        o_ticks_next = o_ticks_reg;
        o_ne_next    = o_ne_reg;
        o_last_next  = o_last_reg;
        cmd_valid_next = cmd_valid_reg;

        if (ctl.step && ctl.word.emit)
        begin
            cmd_valid_next = 1'b1;
            o_act_next   = ctl.word.act;
            o_type_next  = '0;
            o_seq_next   = '0;
            o_ack_next   = '0;
            o_slot_next  = '0;
            o_len_next   = '0;
            o_ticks_next = '0;
            o_ne_next    = 1'b0;
            o_last_next  = 1'b0;
            case (ctl.word.act)
                ACT_SEND:
                begin
                    o_type_next = stype_reg;
                    o_seq_next  = to_seq_field(sseq_reg);
                    o_ack_next  = to_seq_field(seq_dec(rle_reg));
                    if (stype_reg == TYPE_DATA)
                        o_slot_next = to_slot_field(sslot);
                end
                ACT_DELIVER:
                begin
                    o_slot_next = to_slot_field(rslot);
                    o_len_next  = plen;
                end
                ACT_START_DATA:
                begin
                    o_slot_next  = to_slot_field(sslot);
                    o_ticks_next = data_to_reg;
                end
                ACT_STOP_DATA:
                begin
                    o_slot_next = to_slot_field(oslot);
                end
                ACT_START_ACK:
                begin
                    o_ticks_next = ack_to_reg;
                end
                ACT_STATUS:
                begin
                    o_ne_next   = (outc_reg < OC_W'(W)) && phys_reg;
                    o_last_next = 1'b1;
                end
                default: ;
            endcase
        end
        else if (cmd.ready)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nts_reg       <= '0;
            old_reg       <= '0;
            rle_reg       <= '0;
            rue_reg       <= SW'(W);
            outc_reg      <= '0;
            arr_reg       <= '0;
            nak_ok_reg    <= 1'b1;
            phys_reg      <= 1'b0;
            data_to_reg   <= DATA_TO_RESET;
            ack_to_reg    <= ACK_TO_RESET;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            nts_reg       <= nts_next;
            old_reg       <= old_next;
            rle_reg       <= rle_next;
            rue_reg       <= rue_next;
            outc_reg      <= outc_next;
            arr_reg       <= arr_next;
            nak_ok_reg    <= nak_ok_next;
            phys_reg      <= phys_next;
            data_to_reg   <= data_to_next;
            ack_to_reg    <= ack_to_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sseq_reg    <= sseq_next;
        stype_reg   <= stype_next;
        o_act_reg   <= o_act_next;
        o_type_reg  <= o_type_next;
        o_seq_reg   <= o_seq_next;
        o_ack_reg   <= o_ack_next;
        o_slot_reg  <= o_slot_next;
        o_len_reg   <= o_len_next;
        o_ticks_reg <= o_ticks_next;
        o_ne_reg    <= o_ne_next;
        o_last_reg  <= o_last_next;
        if (evt_fire)
        begin
            kind_reg  <= evt.kind;
            good_reg  <= evt.frame_good;
            ftype_reg <= evt.frame_type;
            fseq_reg  <= seq_in(evt.frame_seq);
            fack_reg  <= seq_in(evt.peer_ack);
            flen_reg  <= evt.frame_length;
            tslot_reg <= tslot_in(evt.timer_slot);
        end
    end

    assign cmd.valid          = cmd_valid_reg;
    assign cmd.action         = o_act_reg;
    assign cmd.send_type      = o_type_reg;
    assign cmd.send_seq       = o_seq_reg;
    assign cmd.send_ack       = o_ack_reg;
    assign cmd.buffer_slot    = o_slot_reg;
    assign cmd.packet_length  = o_len_reg;
    assign cmd.timer_ticks    = o_ticks_reg;
    assign cmd.network_enable = o_ne_reg;
    assign cmd.last           = o_last_reg;

    // never more frames outstanding than the window
    a_outc: assert property (@(posedge clk) disable iff (!rst_n)
        outc_reg <= OC_W'(W))
        else $error("outstanding count beyond window");

    // receive window keeps its width
    a_rx_window: assert property (@(posedge clk) disable iff (!rst_n)
        rue_reg == seq_add_w(rle_reg))
        else $error("receive window edges out of step");

    // last flag marks the status beat and nothing else
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg |-> (o_last_reg == (o_act_reg == ACT_STATUS)))
        else $error("last flag on a non-status beat");

    // an accepted event starts the program
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        evt_fire |=> ctl.busy)
        else $error("event accepted without starting the sequencer");

endmodule

[design/sra_seq.sv]
module sra_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              out_free,
    input  logic              cond_hit,
    output sra_pkg::seq_ctl_t ctl
);
    import sra_pkg::*;

    pc_t    pc_reg;
    pc_t    pc_next;
    pc_t    ret_reg;
    pc_t    ret_next;
    logic   busy_reg;
    logic   busy_next;
    uword_t word;
    logic   step;

    // fetch, and hold a word that emits while the output register is full
    assign word = rom_word(pc_reg);
    assign step = busy_reg && !(word.emit && !out_free);

    assign ctl.busy = busy_reg;
    assign ctl.step = step;
    assign ctl.word = word;

    // next address: start, finish, return, call, conditional jump or fall through
    always_comb
    begin
        pc_next   = pc_reg;
        ret_next  = ret_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = A_DISP0;
            busy_next = 1'b1;
        end
        else if (step)
        begin
            if (word.fin)
            begin
                busy_next = 1'b0;
                pc_next   = A_DISP0;
            end
            else if (word.ret)
            begin
                pc_next = ret_reg;
            end
            else if (word.call)
            begin
                ret_next = pc_reg + PC_W'(1);
                pc_next  = word.target;
            end
            else if (cond_hit)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
    end

    // program counter, return register and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= A_DISP0;
            ret_reg  <= A_DISP0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            ret_reg  <= ret_next;
            busy_reg <= busy_next;
        end
    end

    // program counter stays inside the control store
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg < PROG_LEN))
        else $error("sequencer left the control store");

    // an idle sequencer waits at the dispatch entry
    a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (pc_reg == A_DISP0))
        else $error("idle sequencer not at dispatch");

    // a word held by a full output register is retried unchanged
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !step) |=> (busy_reg && $stable(pc_reg)))
        else $error("stalled word was skipped");

endmodule
